@@ rtl/dda_line_rasterizer_defines.svh @@
// assertion macros used by the checker file
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

// same-cycle implication, sampled on clk, idle during reset
`define DDA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, idle during reset
`define DDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dda_pkg.sv @@
// shared types and constants of the dda line rasterizer
`default_nettype none

package dda_pkg;

    localparam int COORD_W     = 13;
    localparam int COLOR_W     = 32;
    localparam int ADDR_W      = 26;
    localparam int WIDTH_W     = 13;
    localparam int BPP_W       = 3;
    localparam int PITCH_W     = 15;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_TUSER_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH      = 8'd3;

    localparam logic [WIDTH_W-1:0] RST_SCREEN_WIDTH    = 13'd1024;
    localparam logic [WIDTH_W-1:0] RST_SCREEN_HEIGHT   = 13'd768;
    localparam logic [BPP_W-1:0]   RST_BYTES_PER_PIXEL = 3'd4;
    localparam logic [PITCH_W-1:0] RST_LINE_PITCH      = 15'd4096;

    typedef struct packed {
        logic [WIDTH_W-1:0] screen_width;
        logic [WIDTH_W-1:0] screen_height;
        logic [BPP_W-1:0]   bytes_per_pixel;
        logic [PITCH_W-1:0] line_pitch;
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/dda_front.sv @@
// line setup: deltas, step count and serial division of the increments
`default_nettype none

module dda_front #(
    parameter int MAX_STEPS = 64,
    parameter int FRAC_BITS = 16,
    parameter int CNT_W     = 7,
    parameter int CMD_W     = 102
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [dda_pkg::IN_TDATA_W-1:0] in_data,
    output logic                               cmd_valid,
    input  wire logic                          cmd_ready,
    output logic [CMD_W-1:0]                   cmd_data
);
    import dda_pkg::*;

    localparam int STEP_W = FRAC_BITS + 2;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int ITER_W = $clog2(FRAC_BITS + 1);

    typedef struct packed {
        logic [COLOR_W-1:0]       color;
        logic                     cut;
        logic [CNT_W-1:0]         count;
        logic signed [STEP_W-1:0] step_y;
        logic signed [STEP_W-1:0] step_x;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x0;
    } cmd_t;

    typedef enum logic [1:0] {F_IDLE, F_CALC, F_DIV, F_PUSH} state_t;

    state_t state_reg, state_next;

    logic signed [COORD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [COLOR_W-1:0]        color_reg;
    logic                      negx_reg, negy_reg, cut_reg;
    logic [COORD_W-1:0]        steps_reg;
    logic [COORD_W-1:0]        rx_reg, ry_reg;
    logic [Q_W-1:0]            qx_reg, qy_reg;
    logic [ITER_W-1:0]         iter_reg;
    logic [CNT_W-1:0]          count_reg;

    logic signed [COORD_W:0] dx, dy, adx_w, ady_w;
    logic [COORD_W-1:0]      adx, ady, steps;
    logic                    bx0, by0;
    logic [COORD_W:0]        shx, shy;
    logic                    bx, by;
    logic signed [STEP_W-1:0] sx, sy;
    cmd_t                    cmd;

    // setup: deltas, magnitudes, step count, top quotient bit
    always_comb
    begin
        dx    = {x1_reg[COORD_W-1], x1_reg} - {x0_reg[COORD_W-1], x0_reg};
        dy    = {y1_reg[COORD_W-1], y1_reg} - {y0_reg[COORD_W-1], y0_reg};
        adx_w = dx[COORD_W] ? -dx : dx;
        ady_w = dy[COORD_W] ? -dy : dy;
        adx   = adx_w[COORD_W-1:0];
        ady   = ady_w[COORD_W-1:0];
        steps = (adx > ady) ? adx : ady;
        bx0   = (adx >= steps);
        by0   = (ady >= steps);
    end

    // one restoring division step per axis
    always_comb
    begin
        shx = {rx_reg, 1'b0};
        shy = {ry_reg, 1'b0};
        bx  = (shx >= {1'b0, steps_reg});
        by  = (shy >= {1'b0, steps_reg});
    end

    always_comb
    begin
        sx = negx_reg ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
        sy = negy_reg ? -$signed({1'b0, qy_reg}) : $signed({1'b0, qy_reg});
        cmd.color  = color_reg;
        cmd.cut    = cut_reg;
        cmd.count  = count_reg;
        cmd.step_y = sy;
        cmd.step_x = sx;
        cmd.y0     = y0_reg;
        cmd.x0     = x0_reg;
        cmd_data   = cmd;
    end

    assign in_ready  = (state_reg == F_IDLE);
    assign cmd_valid = (state_reg == F_PUSH);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (in_valid) state_next = F_CALC;
            F_CALC: state_next = (steps == '0) ? F_IDLE : F_DIV;
            F_DIV:  if (iter_reg == ITER_W'(1)) state_next = F_PUSH;
            F_PUSH: if (cmd_ready) state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
        begin
            x0_reg    <= in_data[COORD_W-1:0];
            y0_reg    <= in_data[2*COORD_W-1:COORD_W];
            x1_reg    <= in_data[3*COORD_W-1:2*COORD_W];
            y1_reg    <= in_data[4*COORD_W-1:3*COORD_W];
            color_reg <= in_data[4*COORD_W+COLOR_W-1:4*COORD_W];
        end
        if (state_reg == F_CALC)
        begin
            negx_reg  <= dx[COORD_W];
            negy_reg  <= dy[COORD_W];
            steps_reg <= steps;
            rx_reg    <= bx0 ? adx - steps : adx;
            ry_reg    <= by0 ? ady - steps : ady;
            qx_reg    <= Q_W'(bx0);
            qy_reg    <= Q_W'(by0);
            iter_reg  <= ITER_W'(FRAC_BITS);
            cut_reg   <= (steps > COORD_W'(MAX_STEPS));
            count_reg <= (steps > COORD_W'(MAX_STEPS)) ? CNT_W'(MAX_STEPS)
                                                        : steps[CNT_W-1:0];
        end
        if (state_reg == F_DIV)
        begin
            rx_reg   <= bx ? COORD_W'(shx - {1'b0, steps_reg}) : shx[COORD_W-1:0];
            ry_reg   <= by ? COORD_W'(shy - {1'b0, steps_reg}) : shy[COORD_W-1:0];
            qx_reg   <= {qx_reg[Q_W-2:0], bx};
            qy_reg   <= {qy_reg[Q_W-2:0], by};
            iter_reg <= iter_reg - ITER_W'(1);
        end
    end

endmodule

`default_nettype wire

@@ rtl/dda_queue.sv @@
// two-entry command queue between setup and drawing
`default_nettype none

module dda_queue #(
    parameter int W = 115
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);

    logic [W-1:0] mem [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   fill_reg;
    logic         push, pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dda_back.sv @@
// pixel stepper, clipping and address pipeline
`default_nettype none

module dda_back #(
    parameter int FRAC_BITS = 16,
    parameter int CNT_W     = 7,
    parameter int CMD_W     = 102
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire dda_pkg::cfg_t                    cfg,
    input  wire logic                             cmd_valid,
    output logic                                  cmd_ready,
    input  wire logic [CMD_W-1:0]                 cmd_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [dda_pkg::OUT_TDATA_W-1:0]       out_data,
    output logic [dda_pkg::OUT_TUSER_W-1:0]       out_user,
    output logic                                  out_last
);
    import dda_pkg::*;

    localparam int STEP_W = FRAC_BITS + 2;
    localparam int ACC_W  = COORD_W + FRAC_BITS;
    localparam int PAD_W  = OUT_TDATA_W - 2*COORD_W - ADDR_W - COLOR_W;

    typedef struct packed {
        logic [COLOR_W-1:0]       color;
        logic                     cut;
        logic [CNT_W-1:0]         count;
        logic signed [STEP_W-1:0] step_y;
        logic signed [STEP_W-1:0] step_x;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x0;
    } cmd_t;

    cmd_t cmd;

    logic                     busy_reg;
    logic [ACC_W-1:0]         accx_reg, accy_reg;
    logic [STEP_W-1:0]        stx_reg, sty_reg;
    logic [CNT_W-1:0]         left_reg;
    logic                     cut_reg;
    logic [COLOR_W-1:0]       color_reg;

    logic                     a_valid_reg;
    logic [COORD_W-1:0]       a_px_reg, a_py_reg;
    logic                     a_in_reg, a_last_reg, a_trunc_reg;
    logic [COLOR_W-1:0]       a_color_reg;

    logic                     out_valid_reg;
    logic [OUT_TDATA_W-1:0]   out_data_reg;
    logic [OUT_TUSER_W-1:0]   out_user_reg;
    logic                     out_last_reg;

    logic                     en, pop, adv, final_px;
    logic [COORD_W-1:0]       px, py;
    logic                     on_screen;
    logic [14:0]              mx;
    logic [26:0]              my, addr_sum;
    logic [ADDR_W-1:0]        addr;

    assign cmd       = cmd_data;
    assign en        = !out_valid_reg || out_ready;
    assign pop       = cmd_valid && !busy_reg;
    assign cmd_ready = !busy_reg;
    assign adv       = busy_reg && en;
    assign final_px  = (left_reg == CNT_W'(1));

    // coordinate truncated toward zero
    always_comb
    begin
        px = accx_reg[ACC_W-1:FRAC_BITS]
           + COORD_W'(accx_reg[ACC_W-1] && (|accx_reg[FRAC_BITS-1:0]));
        py = accy_reg[ACC_W-1:FRAC_BITS]
           + COORD_W'(accy_reg[ACC_W-1] && (|accy_reg[FRAC_BITS-1:0]));
        on_screen = !px[COORD_W-1] && !py[COORD_W-1]
                 && (px < cfg.screen_width) && (py < cfg.screen_height);
    end

    always_comb
    begin
        mx       = 15'(a_px_reg[COORD_W-2:0]) * 15'(cfg.bytes_per_pixel);
        my       = 27'(a_py_reg[COORD_W-2:0]) * 27'(cfg.line_pitch);
        addr_sum = my + 27'(mx);
        addr     = a_in_reg ? addr_sum[ADDR_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
            end
            else if (adv && final_px)
            begin
                busy_reg <= 1'b0;
            end
            if (en)
            begin
                a_valid_reg   <= adv;
                out_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            accx_reg  <= {cmd.x0, {FRAC_BITS{1'b0}}};
            accy_reg  <= {cmd.y0, {FRAC_BITS{1'b0}}};
            stx_reg   <= cmd.step_x;
            sty_reg   <= cmd.step_y;
            left_reg  <= cmd.count;
            cut_reg   <= cmd.cut;
            color_reg <= cmd.color;
        end
        else if (adv)
        begin
            accx_reg <= accx_reg + {{(ACC_W-STEP_W){stx_reg[STEP_W-1]}}, stx_reg};
            accy_reg <= accy_reg + {{(ACC_W-STEP_W){sty_reg[STEP_W-1]}}, sty_reg};
            left_reg <= left_reg - CNT_W'(1);
        end
        if (adv)
        begin
            a_px_reg    <= px;
            a_py_reg    <= py;
            a_in_reg    <= on_screen;
            a_last_reg  <= final_px;
            a_trunc_reg <= final_px && cut_reg;
            a_color_reg <= color_reg;
        end
        if (en && a_valid_reg)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, a_color_reg, addr, a_py_reg, a_px_reg};
            out_user_reg <= {a_trunc_reg, a_in_reg};
            out_last_reg <= a_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/dda_line_rasterizer.sv @@
// Fixed-point DDA line rasterizer. Each input beat is one segment; the block
// emits min(steps, MAX_STEPS) pixel beats, steps = max(|dx|, |dy|), starting at
// the start point and leaving out the end point, with tlast on the final pixel.
// Equal endpoints give no output. Setup forms both increments in a bit-serial
// divider and takes a new segment only once the last one is handed on; it runs
// ahead of drawing through a two-entry queue. Drawing emits one pixel per cycle
// while the output is not stalled, after loading each line from the queue.
// Pixels leave a two-stage clip and address pipeline. Configuration is to be
// written by the user only while the block is idle; the block does not enforce it.
`default_nettype none

module dda_line_rasterizer #(
    parameter int MAX_STEPS = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // start_x, start_y, end_x, end_y, color, zero pad
    input  wire logic [dda_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // pixel_x, pixel_y, byte_address, pixel_value, zero pad
    output logic [dda_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // write_enable, truncated
    output logic [dda_pkg::OUT_TUSER_W-1:0]         m_axis_tuser,
    output logic                                    m_axis_tlast,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [dda_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dda_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dda_pkg::*;

    localparam int CNT_W  = $clog2(MAX_STEPS + 1);
    localparam int STEP_W = FRAC_BITS + 2;
    localparam int CMD_W  = COLOR_W + 1 + CNT_W + 2*STEP_W + 2*COORD_W;

    cfg_t             cfg_reg;
    logic             q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    logic [CMD_W-1:0] q_in_data, q_out_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width    <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height   <= RST_SCREEN_HEIGHT;
            cfg_reg.bytes_per_pixel <= RST_BYTES_PER_PIXEL;
            cfg_reg.line_pitch      <= RST_LINE_PITCH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:    cfg_reg.screen_width    <= cfg_data[WIDTH_W-1:0];
                CFG_SCREEN_HEIGHT:   cfg_reg.screen_height   <= cfg_data[WIDTH_W-1:0];
                CFG_BYTES_PER_PIXEL: cfg_reg.bytes_per_pixel <= cfg_data[BPP_W-1:0];
                CFG_LINE_PITCH:      cfg_reg.line_pitch      <= cfg_data[PITCH_W-1:0];
                default:             ;
            endcase
        end
    end

    dda_front #(
        .MAX_STEPS (MAX_STEPS),
        .FRAC_BITS (FRAC_BITS),
        .CNT_W     (CNT_W),
        .CMD_W     (CMD_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .cmd_valid (q_in_valid),
        .cmd_ready (q_in_ready),
        .cmd_data  (q_in_data)
    );

    dda_queue #(
        .W (CMD_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    dda_back #(
        .FRAC_BITS (FRAC_BITS),
        .CNT_W     (CNT_W),
        .CMD_W     (CMD_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (q_out_valid),
        .cmd_ready (q_out_ready),
        .cmd_data  (q_out_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/dda_checker.sv @@
// port-level assertions for the dda line rasterizer, bound to the top level
`default_nettype none

`include "dda_line_rasterizer_defines.svh"

module dda_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [dda_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input wire logic [dda_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
    input wire logic                              m_axis_tlast
);
    import dda_pkg::*;

    localparam int Y_MSB    = 2*COORD_W - 1;
    localparam int ADDR_LSB = 2*COORD_W;
    localparam int ADDR_MSB = 2*COORD_W + ADDR_W - 1;

    `DDA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "output beat changed while stalled")

    `DDA_ASSERT_IMPLY(a_clip_addr, m_axis_tvalid && !m_axis_tuser[0],
        m_axis_tdata[ADDR_MSB:ADDR_LSB] == '0,
        "clipped pixel carries a nonzero address")

    `DDA_ASSERT_IMPLY(a_trunc_last, m_axis_tvalid && m_axis_tuser[1],
        m_axis_tlast,
        "truncated flag on a pixel that is not the last")

    `DDA_ASSERT_IMPLY(a_we_coords, m_axis_tvalid && m_axis_tuser[0],
        !m_axis_tdata[COORD_W-1] && !m_axis_tdata[Y_MSB],
        "written pixel has a negative coordinate")

endmodule

bind dda_line_rasterizer dda_checker u_checker (.*);

`default_nettype wire

@@ tb/dda_line_rasterizer_tb.sv @@
// self-checking testbench for the dda line rasterizer: lines in, predicted pixels checked
`timescale 1ns / 1ps

module dda_line_rasterizer_tb;

    import dda_pkg::*;

    localparam int FRAC = 16;
    localparam int STEP_CAP = 64;
    localparam int DRAIN_CYCLES = 100;
    localparam int LONG_HOLD = 400;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_TOP = 8'hFF;

    typedef struct packed {
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [COLOR_W-1:0] color;
    } line_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] value;
        logic               we;
        logic               last;
        logic               cut;
    } pixel_t;

    class pixel_ledger;
        logic [WIDTH_W-1:0] width;
        logic [WIDTH_W-1:0] height;
        logic [BPP_W-1:0]   bpp;
        logic [PITCH_W-1:0] pitch;
        pixel_t pixels_due[$];
        int mismatches;
        int pixels_seen;

        function new();
            width = RST_SCREEN_WIDTH;
            height = RST_SCREEN_HEIGHT;
            bpp = RST_BYTES_PER_PIXEL;
            pitch = RST_LINE_PITCH;
            mismatches = 0;
            pixels_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_SCREEN_WIDTH:    width = data[WIDTH_W-1:0];
                CFG_SCREEN_HEIGHT:   height = data[WIDTH_W-1:0];
                CFG_BYTES_PER_PIXEL: bpp = data[BPP_W-1:0];
                CFG_LINE_PITCH:      pitch = data[PITCH_W-1:0];
                default: ;
            endcase
        endfunction

        function longint fixed_increment(longint d, longint steps);
            longint q;
            q = ((d < 0 ? -d : d) <<< FRAC) / steps;
            return d < 0 ? -q : q;
        endfunction

        function longint to_pixel(longint acc);
            return acc < 0 ? -((-acc) >>> FRAC) : acc >>> FRAC;
        endfunction

        function void add_line(line_t l);
            longint x0, y0, dx, dy, steps, inc_x, inc_y, acc_x, acc_y, px, py, count;
            bit cut;
            pixel_t p;
            x0 = $signed(l.sx);
            y0 = $signed(l.sy);
            dx = longint'($signed(l.ex)) - x0;
            dy = longint'($signed(l.ey)) - y0;
            steps = (dx < 0 ? -dx : dx);
            if ((dy < 0 ? -dy : dy) > steps)
                steps = (dy < 0 ? -dy : dy);
            if (steps == 0)
                return;
            inc_x = fixed_increment(dx, steps);
            inc_y = fixed_increment(dy, steps);
            acc_x = x0 * (longint'(1) <<< FRAC);
            acc_y = y0 * (longint'(1) <<< FRAC);
            cut = steps > STEP_CAP;
            count = cut ? STEP_CAP : steps;
            for (longint i = 0; i < count; i++)
            begin
                px = to_pixel(acc_x);
                py = to_pixel(acc_y);
                p.x = px[COORD_W-1:0];
                p.y = py[COORD_W-1:0];
                p.we = px >= 0 && py >= 0 && px < longint'(width) && py < longint'(height);
                p.addr = p.we ? ADDR_W'(px * bpp + py * pitch) : '0;
                p.value = l.color;
                p.last = (i == count - 1);
                p.cut = p.last && cut;
                pixels_due.push_back(p);
                acc_x += inc_x;
                acc_y += inc_y;
            end
        endfunction

        task report_mismatch(string field, logic [COLOR_W-1:0] got, logic [COLOR_W-1:0] want);
            $display("pixel %0d: %s got %0h expected %0h", pixels_seen, field, got, want);
            mismatches++;
        endtask

        task check_pixel(pixel_t got);
            pixel_t want;
            pixels_seen++;
            if (pixels_due.size() == 0)
            begin
                report_mismatch("unexpected beat, x", got.x, '0);
                return;
            end
            want = pixels_due.pop_front();
            if (got.x !== want.x) report_mismatch("pixel_x", got.x, want.x);
            if (got.y !== want.y) report_mismatch("pixel_y", got.y, want.y);
            if (got.addr !== want.addr) report_mismatch("byte_address", got.addr, want.addr);
            if (got.value !== want.value) report_mismatch("pixel_value", got.value, want.value);
            if (got.we !== want.we) report_mismatch("write_enable", got.we, want.we);
            if (got.last !== want.last) report_mismatch("last", got.last, want.last);
            if (got.cut !== want.cut) report_mismatch("truncated", got.cut, want.cut);
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    pixel_ledger ledger = new();
    bit no_idle = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;
    int lines_sent = 0;
    int settings_used = 1;
    int cycles = 0;

    dda_line_rasterizer DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // output side: random backpressure plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (holds_asked != holds_served)
            begin
                hold_left = LONG_HOLD;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 27);
        end
    end

    always @(posedge clk)
    begin
        pixel_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.x = m_axis_tdata[12:0];
            got.y = m_axis_tdata[25:13];
            got.addr = m_axis_tdata[51:26];
            got.value = m_axis_tdata[83:52];
            got.we = m_axis_tuser[0];
            got.cut = m_axis_tuser[1];
            got.last = m_axis_tlast;
            ledger.check_pixel(got);
        end
    end

    task automatic send_line(line_t l);
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 27)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, l.color, l.ey, l.ex, l.sy, l.sx};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        ledger.add_line(l);
        lines_sent++;
    endtask

    task automatic draw(int sx, int sy, int ex, int ey, logic [COLOR_W-1:0] color);
        line_t l;
        l.sx = sx[COORD_W-1:0];
        l.sy = sy[COORD_W-1:0];
        l.ex = ex[COORD_W-1:0];
        l.ey = ey[COORD_W-1:0];
        l.color = color;
        send_line(l);
    endtask

    function automatic int fit13(int v);
        return v < -4096 ? -4096 : (v > 4095 ? 4095 : v);
    endfunction

    // mostly short lines around the visible area, some long random ones
    task automatic draw_random(int count);
        int mode, w, h, x0, y0, x1, y1;
        line_t l;
        for (int i = 0; i < count; i++)
        begin
            mode = $urandom_range(0, 99);
            w = ledger.width == 0 ? 64 : (ledger.width > 4000 ? 4000 : int'(ledger.width));
            h = ledger.height == 0 ? 64 : (ledger.height > 4000 ? 4000 : int'(ledger.height));
            l.color = $urandom;
            if (mode < 15)
            begin
                l.sx = COORD_W'($urandom);
                l.sy = COORD_W'($urandom);
                l.ex = COORD_W'($urandom);
                l.ey = COORD_W'($urandom);
                send_line(l);
            end
            else
            begin
                x0 = int'($urandom_range(0, w + 40)) - 20;
                y0 = int'($urandom_range(0, h + 40)) - 20;
                x1 = x0;
                y1 = y0;
                if (mode >= 20)
                begin
                    x1 = x0 + int'($urandom_range(0, 140)) - 70;
                    y1 = y0 + int'($urandom_range(0, 140)) - 70;
                end
                draw(fit13(x0), fit13(y0), fit13(x1), fit13(y1), l.color);
            end
        end
    endtask

    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (ledger.pixels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        ledger.write_reg(index, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_screen(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                              logic [CFG_DATA_W-1:0] bpp, logic [CFG_DATA_W-1:0] pitch);
        settle();
        write_reg(CFG_SCREEN_WIDTH, w);
        write_reg(CFG_SCREEN_HEIGHT, h);
        write_reg(CFG_BYTES_PER_PIXEL, bpp);
        write_reg(CFG_LINE_PITCH, pitch);
        settings_used++;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // directed lines on the reset screen
        draw(0, 0, 0, 0, 32'h0);
        draw(0, 0, 10, 0, 32'hFFFF_FFFF);
        draw(10, 5, 0, 5, 32'h1234_5678);
        draw(3, 0, 3, 12, 32'hA5A5_A5A5);
        draw(3, 12, 3, 0, 32'h5A5A_5A5A);
        draw(0, 0, 7, 3, 32'h0000_0001);
        draw(7, 3, 0, 0, 32'h8000_0000);
        draw(-5, -5, 5, 3, 32'hDEAD_BEEF);
        draw(0, 0, -3, -50, 32'hCAFE_F00D);
        draw(0, 0, 64, 0, 32'h0F0F_0F0F);
        draw(0, 0, 65, 20, 32'hF0F0_F0F0);
        draw(-4096, -4096, 4095, 4095, 32'hFFFF_0000);
        draw(4095, 4095, -4096, -4096, 32'h0000_FFFF);
        draw(4095, -4096, -4096, 4095, 32'h1357_9BDF);
        draw(1020, 765, 1030, 770, 32'h2468_ACE0);
        draw(-3, -3, 3, 3, 32'h7777_7777);
        draw(100, 100, 100, 100, 32'h3333_3333);
        draw(-4096, 0, -4096, 5, 32'h4444_4444);
        draw(0, 0, 1, 1, 32'h5555_5555);
        draw(5, 0, 4, -1, 32'h6666_6666);
        draw(1023, 767, 1024, 768, 32'h9999_9999);

        // receiver holds off long enough for the input to back up
        holds_asked++;
        draw_random(20);

        set_screen(16'd4096, 16'd4096, 16'd4, 16'd16384);
        no_idle = 1;
        draw_random(20);
        no_idle = 0;

        set_screen(16'd1, 16'd1, 16'd1, 16'd1);
        write_reg(CFG_INDEX_TOP, 16'h0BAD);
        draw(-1, -1, 2, 2, 32'hAAAA_5555);
        draw(0, 0, 0, 3, 32'h5555_AAAA);
        draw(1, 0, -2, 0, 32'h0F00_00F0);
        draw_random(10);

        // zero-width screen, remaining registers written with masked-off high bits
        set_screen(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        draw_random(10);

        set_screen(16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)),
                   16'($urandom_range(1, 4)), 16'($urandom_range(1, 16384)));
        draw_random(15);

        settle();
        $display("%0d lines sent, %0d pixel beats checked, %0d screen settings",
                 lines_sent, ledger.pixels_seen, settings_used);
        $display("covered clipping, truncation of long lines, masked and ignored writes");
        if (ledger.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ dda_line_rasterizer.f @@
+incdir+rtl
rtl/dda_pkg.sv
rtl/dda_front.sv
rtl/dda_queue.sv
rtl/dda_back.sv
rtl/dda_line_rasterizer.sv
rtl/dda_checker.sv
tb/dda_line_rasterizer_tb.sv
